// File: src/price_time_order_matcher_top_macros.svh
// Assertion macros used by the matcher RTL
`ifndef PRICE_TIME_ORDER_MATCHER_TOP_MACROS_SVH
`define PRICE_TIME_ORDER_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, reset masked
`define PTOM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptom assertion failed");

// Next-cycle implication, reset masked
`define PTOM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptom assertion failed");

`endif

// File: src/ptom_pkg.sv
// Types and constants for the price-time order matcher
`timescale 1ns / 1ps
package ptom_pkg;

  localparam int ORDER_SLOTS_DEF = 32;
  localparam int MAX_FILLS       = 32;
  localparam int FILL_W          = 6;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    KIND_TRADE   = 2'd0,
    KIND_FILLED  = 2'd1,
    KIND_RESTED  = 2'd2,
    KIND_DROPPED = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FILL,
    ST_FINAL
  } state_e;

  typedef struct packed {
    logic        side;
    logic [31:0] order_id;
    logic [15:0] limit_price;
    logic [31:0] order_qty;
  } order_t;

  typedef struct packed {
    order_t ord;
    logic   zero_qty;
  } qitem_t;

  typedef struct packed {
    logic        side;
    logic [15:0] price;
    logic [31:0] qty;
    logic [31:0] owner;
    logic [31:0] arrival;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] taker_id;
    logic [31:0] maker_id;
    logic [31:0] fill_qty;
    logic [15:0] fill_price;
    logic [31:0] remaining_qty;
    logic        last;
  } result_t;

endpackage

// File: src/ptom_front.sv
// Input stage: registers each order and tags zero-quantity orders
`timescale 1ns / 1ps
module ptom_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  ptom_pkg::order_t in_item,
  output logic            push,
  output ptom_pkg::qitem_t push_item,
  input  logic            q_full
);
  import ptom_pkg::*;

  logic   held;
  order_t held_ord;
  logic   take;

  assign in_stall  = held && q_full;
  assign take      = in_valid && !in_stall;
  assign push      = held && !q_full;
  assign push_item = '{ord: held_ord, zero_qty: (held_ord.order_qty == 32'd0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_ord <= in_item;
    end
  end

endmodule

// File: src/ptom_fifo.sv
// Two-entry queue between the input stage and the matching engine
`timescale 1ns / 1ps
module ptom_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ptom_pkg::qitem_t push_item,
  output logic             full,
  output logic             q_valid,
  output ptom_pkg::qitem_t q_item,
  input  logic             pop
);
  import ptom_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qitem_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule

// File: src/ptom_back.sv
// Matching engine: slot store, best-order scan, fills and result register
`timescale 1ns / 1ps
`include "price_time_order_matcher_top_macros.svh"
module ptom_back #(
  parameter int ORDER_SLOTS = ptom_pkg::ORDER_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  ptom_pkg::qitem_t  q_item,
  output logic              pop,
  output logic              out_valid,
  output ptom_pkg::result_t out_res,
  input  logic              out_stall
);
  import ptom_pkg::*;

  localparam int SLOT_W = $clog2(ORDER_SLOTS);

  state_e state, state_next;

  entry_t book [ORDER_SLOTS];
  entry_t rd_ent;
  logic [ORDER_SLOTS-1:0] valid_bits;
  logic [31:0] arrival_ctr;

  order_t            ord;
  logic [31:0]       rem;
  logic [FILL_W-1:0] fills;
  logic [SLOT_W-1:0] scan_idx;
  logic              cmp_valid;
  logic [SLOT_W-1:0] cmp_idx;
  logic              best_found;
  logic [SLOT_W-1:0] best_idx;
  entry_t            best_ent;
  logic [31:0]       best_age;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;

  logic        out_free;
  logic        do_fill;
  logic        do_final;
  logic        do_rest;
  logic        scan_begin;
  logic [31:0] fill_q;
  logic [31:0] rem_after;
  logic [31:0] maker_left;
  logic        fill_ends;

  logic        cand;
  logic        take_best;
  logic        slot_v;
  logic        crosses;
  logic        better_price;
  logic [31:0] age;

  logic              we;
  logic [SLOT_W-1:0] waddr;
  entry_t            wdata;

  assign out_free   = !out_valid || !out_stall;
  assign fill_q     = (rem < best_ent.qty) ? rem : best_ent.qty;
  assign rem_after  = rem - fill_q;
  assign maker_left = best_ent.qty - fill_q;
  assign fill_ends  = (rem_after == 32'd0) || (fills == FILL_W'(MAX_FILLS - 1));

  // Candidate compare on the registered read of the previous scan address
  assign slot_v  = valid_bits[cmp_idx];
  assign crosses = ord.side ? (rd_ent.price >= ord.limit_price)
                            : (rd_ent.price <= ord.limit_price);
  assign age     = arrival_ctr - rd_ent.arrival;
  assign better_price = ord.side ? (rd_ent.price > best_ent.price)
                                 : (rd_ent.price < best_ent.price);
  assign cand      = cmp_valid && slot_v && (rd_ent.side != ord.side) && crosses;
  assign take_best = cand && (!best_found || better_price ||
                     ((rd_ent.price == best_ent.price) && (age > best_age)));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = q_item.zero_qty ? ST_FINAL : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx == SLOT_W'(ORDER_SLOTS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FILL;
      end
      ST_FILL: begin
        if (!best_found) begin
          state_next = ST_FINAL;
        end else if (out_free) begin
          state_next = fill_ends ? ST_FINAL : ST_SCAN;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pop        = (state == ST_IDLE) && q_valid;
    do_fill    = (state == ST_FILL) && best_found && out_free;
    do_final   = (state == ST_FINAL) && out_free;
    do_rest    = do_final && (rem != 32'd0) && free_found;
    scan_begin = (state != ST_SCAN) && (state_next == ST_SCAN);
    we         = do_fill || do_rest;
    waddr      = do_fill ? best_idx : free_idx;
    wdata      = do_fill ? entry_t'{side: best_ent.side, price: best_ent.price,
                                    qty: maker_left, owner: best_ent.owner,
                                    arrival: best_ent.arrival}
                         : entry_t'{side: ord.side, price: ord.limit_price, qty: rem,
                                    owner: ord.order_id, arrival: arrival_ctr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      valid_bits  <= '0;
      arrival_ctr <= '0;
      out_valid   <= 1'b0;
      cmp_valid   <= 1'b0;
      best_found  <= 1'b0;
      free_found  <= 1'b0;
      scan_idx    <= '0;
      fills       <= '0;
    end else begin
      state     <= state_next;
      cmp_valid <= (state == ST_SCAN);
      if (pop) begin
        fills <= '0;
      end
      if (scan_begin) begin
        scan_idx   <= '0;
        best_found <= 1'b0;
        // a maker emptied by the fill that starts this scan is already a free slot
        free_found <= do_fill && (maker_left == 32'd0);
      end else begin
        if (state == ST_SCAN) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (take_best) begin
          best_found <= 1'b1;
        end
        if (cmp_valid && !slot_v && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (do_fill) begin
        fills <= fills + 1'b1;
        if (maker_left == 32'd0) begin
          valid_bits[best_idx] <= 1'b0;
          if (!scan_begin) begin
            free_found <= 1'b1;
          end
        end
      end
      if (do_rest) begin
        valid_bits[free_idx] <= 1'b1;
        arrival_ctr <= arrival_ctr + 32'd1;
      end
      if (do_fill || do_final) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (pop) begin
      ord <= q_item.ord;
      rem <= q_item.ord.order_qty;
    end
    if (take_best && !scan_begin) begin
      best_idx <= cmp_idx;
      best_ent <= rd_ent;
      best_age <= age;
    end
    if (cmp_valid && !slot_v && !free_found && !scan_begin) begin
      free_idx <= cmp_idx;
    end
    if (do_fill) begin
      rem <= rem_after;
      if ((maker_left == 32'd0) && (!free_found || (best_idx < free_idx))) begin
        free_idx <= best_idx;
      end
      out_res <= '{kind: KIND_TRADE, taker_id: ord.order_id, maker_id: best_ent.owner,
                   fill_qty: fill_q, fill_price: best_ent.price,
                   remaining_qty: rem_after, last: 1'b0};
    end else if (do_final) begin
      out_res <= '{kind: (rem == 32'd0) ? KIND_FILLED :
                         (free_found ? KIND_RESTED : KIND_DROPPED),
                   taker_id: ord.order_id, maker_id: 32'd0, fill_qty: 32'd0,
                   fill_price: 16'd0, remaining_qty: rem, last: 1'b1};
    end
  end

  // Slot store
  always_ff @(posedge clk) begin
    if (we) begin
      book[waddr] <= wdata;
    end
    rd_ent <= book[scan_idx];
  end

  `PTOM_ASSERT_IMP(a_fill_cap, 1'b1, fills <= FILL_W'(MAX_FILLS))
  `PTOM_ASSERT_IMP(a_load_free, (do_fill || do_final) && out_valid, !out_stall)
  `PTOM_ASSERT_IMP(a_fill_has_maker, do_fill, valid_bits[best_idx])
  `PTOM_ASSERT_NXT(a_rest_sets_valid, do_rest, valid_bits[$past(free_idx)])

endmodule

// File: src/price_time_order_matcher_top.sv
// Price-time priority limit order matcher, top level
// Input channel (in_valid/in_stall): one limit order per transaction with
// side, order_id, limit_price and order_qty. Output channel
// (out_valid/out_stall): result transactions, one per fill (kind trade) then
// one final result (filled, rested or dropped) flagged by last.
// An order enters a holding register and a two-entry queue; the matching
// engine then scans the slot store one slot per cycle through its single
// read port, and each fill follows a full scan of every slot; a
// zero-quantity order skips the scan and goes straight to its final result.
// New orders are taken into the queue while the engine works, and the
// engine runs on while one result waits in the output register.
// If the receiver stalls, the output register holds its result and the
// engine waits before loading the next one; nothing is lost.
// Reset empties the book, clears the arrival counter and the queue; slot
// contents are used only after they are written, so no clearing pass runs.
`timescale 1ns / 1ps
module price_time_order_matcher_top #(
  parameter int ORDER_SLOTS = ptom_pkg::ORDER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        side,
  input  logic [31:0] order_id,
  input  logic [15:0] limit_price,
  input  logic [31:0] order_qty,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [31:0] taker_id,
  output logic [31:0] maker_id,
  output logic [31:0] fill_qty,
  output logic [15:0] fill_price,
  output logic [31:0] remaining_qty,
  output logic        last
);
  import ptom_pkg::*;

  order_t  in_item;
  qitem_t  push_item;
  qitem_t  q_item;
  result_t out_res;
  logic    push;
  logic    q_full;
  logic    q_valid;
  logic    pop;

  assign in_item = '{side: side, order_id: order_id, limit_price: limit_price,
                     order_qty: order_qty};

  ptom_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  ptom_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  ptom_back #(
    .ORDER_SLOTS (ORDER_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_stall (out_stall)
  );

  assign kind          = out_res.kind;
  assign taker_id      = out_res.taker_id;
  assign maker_id      = out_res.maker_id;
  assign fill_qty      = out_res.fill_qty;
  assign fill_price    = out_res.fill_price;
  assign remaining_qty = out_res.remaining_qty;
  assign last          = out_res.last;

endmodule
